>>> design/bms_pkg.sv
package bms_pkg;

    localparam int BMS_MAX_ITEMS = 64;
    localparam int BMS_DATA_W    = 32;

    typedef logic signed [BMS_DATA_W-1:0] t_data;

    // per-cell control, set by the top level each cycle
    typedef struct packed {
        logic insert;    // broadcast value is being inserted this cycle
        logic shift;     // output taken: move every value one place towards cell 0
        logic occupied;  // cell holds a value of the current batch
        logic at_tail;   // cell is the first free place
    } t_cell_ctrl;

endpackage

>>> design/batch_merge_sorter_core.sv
// A batch of N items is taken at one item per cycle; the first sorted item is shown
// in the cycle after the flagged item is accepted, then one item per cycle while
// i_out_stall is low. Fill and drain phases share the single row of cells, so a new
// batch is taken only once the last one has drained. Input stalls while draining.
// Reset: i_rst_n synchronous active low clears fill count, overflow flag and state;
// the cell contents are not reset.
module batch_merge_sorter_core #(
    parameter int MAX_ITEMS = bms_pkg::BMS_MAX_ITEMS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  bms_pkg::t_data         i_value,
    input  logic                   i_last_in_batch,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output bms_pkg::t_data         o_sorted_value,
    output logic                   o_last_out,
    output logic                   o_overflowed
);
    import bms_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;

    logic in_acc;
    logic out_acc;
    logic full;

    t_data w_value [MAX_ITEMS];
    logic  w_gt    [MAX_ITEMS];

    // Take items only while filling; the row of cells is busy while it drains.
    assign o_in_stall  = (r_state == ST_DRAIN);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == ST_DRAIN);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign full        = (r_cnt == CNT_W'(MAX_ITEMS));

    // Cell 0 always holds the smallest remaining value, so it drives the output.
    assign o_sorted_value = w_value[0];
    assign o_last_out     = (r_cnt == CNT_W'(1));
    assign o_overflowed   = r_ovf;

    // Sorted row of cells. An insert pushes every greater value one place up and
    // drops the new value into the gap; a drain shifts everything down by one.
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        t_cell_ctrl ctrl;
        t_data      left_value;
        logic       left_gt;
        t_data      right_value;

        assign ctrl.insert   = in_acc && !full;
        assign ctrl.shift    = out_acc;
        assign ctrl.occupied = (r_cnt > CNT_W'(i));
        assign ctrl.at_tail  = (r_cnt == CNT_W'(i));

        if (i == 0) begin : g_first
            assign left_value = '0;
            assign left_gt    = 1'b0;
        end else begin : g_inner
            assign left_value = w_value[i-1];
            assign left_gt    = w_gt[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_end
            assign right_value = '0;
        end else begin : g_mid
            assign right_value = w_value[i+1];
        end

        bms_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_new_value   (i_value),
            .i_left_value  (left_value),
            .i_left_gt     (left_gt),
            .i_right_value (right_value),
            .o_value       (w_value[i]),
            .o_gt          (w_gt[i])
        );
    end

    // Hold state, fill count and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_FILL: begin
                    if (in_acc) begin
                        // drop the item once the row is full, but flag the overflow
                        if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        if (i_last_in_batch) begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (out_acc) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                        // advance to the next batch after the final item
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= ST_FILL;
                            r_ovf   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_FILL;
                end
            endcase
        end
    end

endmodule

>>> design/bms_cell.sv
module bms_cell (
    input  logic              i_clk,
    input  bms_pkg::t_cell_ctrl i_ctrl,
    input  bms_pkg::t_data    i_new_value,
    input  bms_pkg::t_data    i_left_value,
    input  logic              i_left_gt,
    input  bms_pkg::t_data    i_right_value,
    output bms_pkg::t_data    o_value,
    output logic              o_gt
);
    import bms_pkg::*;

    t_data r_value;
    t_data n_value;

    // stored value is greater than the incoming one: it must move one place up
    assign o_gt    = i_ctrl.occupied && (r_value > i_new_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.shift) begin
            n_value = i_right_value;
        end else if (i_ctrl.insert) begin
            if (i_left_gt) begin
                n_value = i_left_value;
            end else if (o_gt || i_ctrl.at_tail) begin
                n_value = i_new_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bms_pkg::*;

    // Capacity of the sorter under test; batches longer than this overflow.
    localparam int CAP        = BMS_MAX_ITEMS;
    // Give up well beyond the slowest legal run (about two hundred items, heavy stalls).
    localparam int CYCLE_CAP  = 200000;
    // Quiet cycles after the last result: the first item shows in the cycle after the flag.
    localparam int DRAIN_TAIL = 16;

    // One sorted item as it should leave the block.
    typedef struct {
        t_data value;
        logic  last;
        logic  ovf;
    } t_sorted_item;

    logic  i_clk           = 1'b0;
    logic  i_rst_n         = 1'b0;
    logic  i_in_valid      = 1'b0;
    t_data i_value         = '0;
    logic  i_last_in_batch = 1'b0;
    logic  i_out_stall     = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_data o_sorted_value;
    logic  o_last_out;
    logic  o_overflowed;

    // Idle rates in percent per cycle, changed between phases of the run.
    int unsigned send_idle_pct = 0;
    int unsigned take_idle_pct = 0;

    int unsigned errors = 0;
    int unsigned cycles = 0;

    // Predictor state: the current batch kept in ascending order as it arrives.
    t_data held[CAP];
    int    held_n  = 0;
    logic  dropped = 1'b0;

    // Sorted items that the block still owes us, oldest first.
    t_sorted_item pending_sorted[$];

    batch_merge_sorter_core #(
        .MAX_ITEMS(CAP)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_last_in_batch(i_last_in_batch),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflowed   (o_overflowed)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: end the run if the block stops making progress.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Fold one accepted item into the predicted batch. A full store drops the
    // item and marks the batch; the flagged item releases the whole batch in
    // ascending signed order and empties the store again.
    function automatic void absorb_item(input t_data val, input logic last);
        int           pos;
        t_sorted_item item;
        if (held_n < CAP) begin
            pos = held_n;
            // insertion keeps the held values sorted, so release is a plain walk
            while (pos > 0 && held[pos-1] > val) begin
                held[pos] = held[pos-1];
                pos--;
            end
            held[pos] = val;
            held_n++;
        end else begin
            dropped = 1'b1;
        end
        if (last) begin
            for (int k = 0; k < held_n; k++) begin
                item.value = held[k];
                item.last  = (k == held_n - 1);
                item.ovf   = dropped;
                pending_sorted = {pending_sorted, item};
            end
            held_n  = 0;
            dropped = 1'b0;
        end
    endfunction

    // Offer one item and hold it until the block takes it. Valid is lowered only
    // when an idle cycle is inserted, so back-to-back items keep it high.
    task automatic send_item(input t_data val, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_value         <= val;
        i_last_in_batch <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        absorb_item(val, last);
    endtask

    // Take results when the block offers them and compare each with the oldest
    // prediction; draw the next stall decision every cycle.
    always @(posedge i_clk) begin : take_results
        t_sorted_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_sorted.size() == 0) begin
                $error("unexpected item: sorted_value %0d last_out %0b overflowed %0b",
                       o_sorted_value, o_last_out, o_overflowed);
                errors++;
            end else begin
                want = pending_sorted.pop_front();
                if (o_sorted_value !== want.value) begin
                    $error("sorted_value: expected %0d, got %0d", want.value, o_sorted_value);
                    errors++;
                end
                if (o_last_out !== want.last) begin
                    $error("last_out: expected %0b, got %0b", want.last, o_last_out);
                    errors++;
                end
                if (o_overflowed !== want.ovf) begin
                    $error("overflowed: expected %0b, got %0b", want.ovf, o_overflowed);
                    errors++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < take_idle_pct);
    end

    // Draw a value: mostly full-width random, often a narrow band around zero
    // so that equal values turn up, sometimes one of the two extremes.
    function automatic t_data pick_value();
        case ($urandom_range(9))
            6, 7:    return t_data'($urandom_range(8)) - t_data'(4);
            8:       return {1'b1, {(BMS_DATA_W-1){1'b0}}};
            9:       return {1'b0, {(BMS_DATA_W-1){1'b1}}};
            default: return t_data'($urandom);
        endcase
    endfunction

    // Batches of one item: each value, the two extremes among them, must come straight back, flagged last.
    task automatic test_single_items();
        send_item({1'b1, {(BMS_DATA_W-1){1'b0}}}, 1'b1);
        send_item({1'b0, {(BMS_DATA_W-1){1'b1}}}, 1'b1);
        send_item('0, 1'b1);
        send_item('1, 1'b1);
    endtask

    // Mixed signs with repeats: signed ordering and equal values side by side.
    task automatic test_signs_and_repeats();
        send_item({1'b0, {(BMS_DATA_W-1){1'b1}}}, 1'b0);
        send_item({1'b1, {(BMS_DATA_W-1){1'b0}}}, 1'b0);
        send_item('1, 1'b0);
        send_item('0, 1'b0);
        send_item(t_data'(1), 1'b0);
        send_item({1'b1, {(BMS_DATA_W-1){1'b0}}}, 1'b0);
        send_item('1, 1'b0);
        send_item({1'b0, {(BMS_DATA_W-1){1'b1}}}, 1'b1);
    endtask

    // Already ascending, then strictly descending input.
    task automatic test_presorted();
        for (int i = 0; i < 5; i++)
            send_item(t_data'(i * 1000 - 2000), i == 4);
        for (int i = 0; i < 5; i++)
            send_item(t_data'(40000 - i * 17000), i == 4);
    endtask

    // Fill the store exactly, then overrun it so that the flagged item itself
    // is dropped; follow with a short batch to see the overflow mark cleared.
    task automatic test_store_full();
        for (int i = 0; i < CAP; i++)
            send_item(pick_value(), i == CAP - 1);
        for (int i = 0; i < CAP + 3; i++)
            send_item(pick_value(), i == CAP + 2);
        send_item(pick_value(), 1'b0);
        send_item(pick_value(), 1'b1);
    endtask

    // Random well-formed batches, mostly short, now and then around capacity;
    // trim the final batch so that exactly n_items are sent.
    task automatic test_random_batches(input int n_items);
        int sent;
        int len;
        int roll;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(99);
            if (roll < 4)
                len = $urandom_range(CAP + 6, CAP - 2);
            else if (roll < 20)
                len = $urandom_range(32, 9);
            else
                len = $urandom_range(8, 1);
            if (len > n_items - sent)
                len = n_items - sent;
            for (int i = 0; i < len; i++)
                send_item(pick_value(), i == len - 1);
            sent += len;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // slow receiver: results pile up behind the stall
        send_idle_pct = 7;
        take_idle_pct = 70;
        test_single_items();
        test_signs_and_repeats();
        test_presorted();
        test_random_batches(15);

        // slow sender: the block waits on input between items
        send_idle_pct = 70;
        take_idle_pct = 7;
        test_store_full();
        test_random_batches(15);

        // both sides flat out
        send_idle_pct = 0;
        take_idle_pct = 0;
        test_random_batches(15);

        // park the input; every sequence above ended on a flagged item
        i_in_valid <= 1'b0;

        while (pending_sorted.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
design/bms_pkg.sv
design/bms_cell.sv
design/batch_merge_sorter_core.sv
tb/tb.sv
